/* src/omv_pkg.sv */
package omv_pkg;
  localparam int NODES_DEF  = 256;
  localparam int CHAINS_DEF = 4;
  localparam int DW         = 32;
  localparam int DIV_STEPS  = 64;
  localparam int QDEPTH     = 4;

  typedef struct packed {
    logic [DW-1:0] count;
    logic [DW-1:0] sample;
    logic          oor;
  } omv_item_t;
endpackage

/* src/omv_ram.sv */
module omv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

/* src/omv_div.sv */
module omv_div
  import omv_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [63:0]     dividend,
  input  logic [DW-1:0]   divisor,
  output logic            done,
  output logic [63:0]     quotient
);
  localparam int CW = $clog2(DIV_STEPS + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [63:0]   quo_r, quo_nxt;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted  = {rem_r, quo_r[63]};
    diff     = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

/* src/omv_front.sv */
module omv_front
  import omv_pkg::*;
#(
  parameter int NODES  = NODES_DEF,
  parameter int CHAINS = CHAINS_DEF,
  parameter int AW     = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          hold,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_chain_index,
  input  logic [7:0]    in_node_index,
  input  logic [DW-1:0] in_sample_count,
  input  logic [DW-1:0] in_log_likelihood,
  output logic          q_valid,
  input  logic          q_pop,
  output omv_item_t     q_item,
  output logic [AW-1:0] q_addr
);
  localparam int PW = $clog2(QDEPTH);

  omv_item_t     item_r [QDEPTH];
  logic [AW-1:0] addr_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          push;
  omv_item_t     cls;
  logic [AW-1:0] cls_addr;

  // classify: range check, zero count as one, flat address
  always_comb begin
    cls.oor    = (int'(in_chain_index) >= CHAINS) || (int'(in_node_index) >= NODES);
    cls.count  = (in_sample_count == '0) ? DW'(1) : in_sample_count;
    cls.sample = in_log_likelihood;
    cls_addr   = AW'(int'(in_chain_index) * NODES + int'(in_node_index));
  end

  assign in_ready = !hold && (cnt_r != (PW+1)'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != '0;
  assign q_item   = item_r[rp_r];
  assign q_addr   = addr_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
    end
    if (push) begin
      item_r[wp_r] <= cls;
      addr_r[wp_r] <= cls_addr;
    end
  end
endmodule

/* src/omv_back.sv */
module omv_back
  import omv_pkg::*;
#(
  parameter int ENTRIES = 1024,
  parameter int AW      = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          clearing,
  input  logic          q_valid,
  output logic          q_pop,
  input  omv_item_t     q_item,
  input  logic [AW-1:0] q_addr,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_running_mean,
  output logic [DW-1:0] out_running_spread,
  output logic          out_spread_saturated
);
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_MUL = 3'd3,
                         S_GO = 3'd4, S_DIV = 3'd5, S_WB = 3'd6;

  logic [2:0]    st_r, st_nxt;
  logic [AW:0]   clr_r;
  omv_item_t     it_r;
  logic [AW-1:0] addr_r;
  logic [DW-1:0] mean_r, var_r, mag_r;
  logic          neg_r;
  logic [63:0]   sq_r, prod_r;
  logic [DW-1:0] res_mean_r, res_var_r;
  logic          res_sat_r;
  logic          ov_r;
  logic [DW-1:0] om_r, os_r;
  logic          osat_r;
  logic [DW-1:0] mean_rd, var_rd;
  logic          ram_wr;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_mean, wr_var;
  logic [DW:0]   delta;
  logic          done_sq, done_var, done_mag;
  logic [63:0]   q_sq, q_var, q_mag;
  logic [63:0]   t1, sum;
  logic [DW-1:0] dvs_var;
  logic          emit;

  assign clearing = (st_r == S_CLR);
  assign q_pop    = (st_r == S_IDLE) && q_valid;
  assign emit     = (st_r == S_WB) && (!ov_r || out_ready);

  assign ram_wr  = clearing || (emit && !it_r.oor);
  assign wr_addr = clearing ? clr_r[AW-1:0] : addr_r;
  assign wr_mean = clearing ? '0 : res_mean_r;
  assign wr_var  = clearing ? '0 : res_var_r;

  omv_ram #(.WIDTH(DW), .DEPTH(ENTRIES), .AW(AW)) u_mean_ram (
    .clk, .wr_en(ram_wr), .wr_addr, .wr_data(wr_mean),
    .rd_en(q_pop), .rd_addr(q_addr), .rd_data(mean_rd)
  );
  omv_ram #(.WIDTH(DW), .DEPTH(ENTRIES), .AW(AW)) u_var_ram (
    .clk, .wr_en(ram_wr), .wr_addr, .wr_data(wr_var),
    .rd_en(q_pop), .rd_addr(q_addr), .rd_data(var_rd)
  );

  assign dvs_var = (it_r.count > DW'(1)) ? it_r.count - DW'(1) : DW'(1);

  omv_div u_div_sq (.clk, .rst_n, .start(st_r == S_GO), .dividend(sq_r),
                    .divisor(it_r.count), .done(done_sq), .quotient(q_sq));
  omv_div u_div_var (.clk, .rst_n, .start(st_r == S_GO), .dividend(prod_r),
                     .divisor(dvs_var), .done(done_var), .quotient(q_var));
  omv_div u_div_mag (.clk, .rst_n, .start(st_r == S_GO), .dividend({32'd0, mag_r}),
                     .divisor(it_r.count), .done(done_mag), .quotient(q_mag));

  assign delta = {it_r.sample[DW-1], it_r.sample} - {mean_rd[DW-1], mean_rd};
  assign t1    = (it_r.count > DW'(1)) ? q_var + (q_sq >> 16) : {32'd0, var_r};
  assign sum   = t1;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLR:  if (clr_r == (AW+1)'(ENTRIES - 1)) st_nxt = S_IDLE;
      S_IDLE: if (q_valid) st_nxt = q_item.oor ? S_WB : S_RD;
      S_RD:   st_nxt = S_MUL;
      S_MUL:  st_nxt = S_GO;
      S_GO:   st_nxt = S_DIV;
      S_DIV:  if (done_sq && done_var && done_mag) st_nxt = S_WB;
      S_WB:   if (emit) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_CLR;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (clearing) begin
        clr_r <= clr_r + 1'b1;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
    if (q_pop) begin
      it_r   <= q_item;
      addr_r <= q_addr;
      // out-of-range words skip straight to write-back with zero results
      res_mean_r <= '0;
      res_var_r  <= '0;
      res_sat_r  <= 1'b0;
    end
    if (st_r == S_RD) begin
      mean_r <= mean_rd;
      var_r  <= var_rd;
      neg_r  <= delta[DW];
      mag_r  <= delta[DW] ? DW'(-delta) : delta[DW-1:0];
    end
    if (st_r == S_MUL) begin
      sq_r   <= 64'(mag_r) * 64'(mag_r);
      prod_r <= 64'(var_r) * 64'(it_r.count - DW'(2));
    end
    if (st_r == S_DIV && done_sq) begin
      res_mean_r <= neg_r ? mean_r - q_mag[DW-1:0] : mean_r + q_mag[DW-1:0];
      res_sat_r  <= sum[63:32] != '0;
      res_var_r  <= (sum[63:32] != '0) ? '1 : sum[DW-1:0];
    end
    if (emit) begin
      om_r   <= res_mean_r;
      os_r   <= res_var_r;
      osat_r <= res_sat_r;
    end
  end

  assign out_valid            = ov_r;
  assign out_running_mean     = om_r;
  assign out_running_spread   = os_r;
  assign out_spread_saturated = osat_r;
endmodule

/* src/online_mean_variance_table_unit.sv */
// Path from input word to result word: queue, table read, squaring, 64
// bit-serial quotient steps, write-back. Words are handled one at a time.
// The next word leaves the queue only once the last one has been written back.
// Reset: synchronous, active low; a clearing pass over all CHAINS*NODES
// entries then zeroes both tables, with in_ready low until it finishes.
module online_mean_variance_table_unit
  import omv_pkg::*;
#(
  parameter int NODES  = NODES_DEF,
  parameter int CHAINS = CHAINS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_chain_index,
  input  logic [7:0]    in_node_index,
  input  logic [31:0]   in_sample_count,
  input  logic signed [31:0] in_log_likelihood,
  output logic          out_valid,
  input  logic          out_ready,
  output logic signed [31:0] out_running_mean,
  output logic [31:0]   out_running_spread,
  output logic          out_spread_saturated
);
  localparam int ENTRIES = CHAINS * NODES;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic          clearing;
  logic          q_valid, q_pop;
  omv_item_t     q_item;
  logic [AW-1:0] q_addr;
  logic [DW-1:0] mean_w;

  // front: classify and queue words
  omv_front #(.NODES(NODES), .CHAINS(CHAINS), .AW(AW)) u_front (
    .clk, .rst_n, .hold(clearing),
    .in_valid, .in_ready, .in_chain_index, .in_node_index,
    .in_sample_count, .in_log_likelihood(in_log_likelihood),
    .q_valid, .q_pop, .q_item, .q_addr
  );

  // back: table read, Welford update, write-back, output register
  omv_back #(.ENTRIES(ENTRIES), .AW(AW)) u_back (
    .clk, .rst_n, .clearing,
    .q_valid, .q_pop, .q_item, .q_addr,
    .out_valid, .out_ready,
    .out_running_mean(mean_w), .out_running_spread,
    .out_spread_saturated
  );

  assign out_running_mean = mean_w;
endmodule
